@@ sv/efs_pkg.sv @@
// Package for the event flag scheduler: opcodes, status codes, and the
// controller/datapath command and status structs. No dependencies.
package efs_pkg;

    localparam logic [1:0] OP_SEND     = 2'd0;
    localparam logic [1:0] OP_CLEAR    = 2'd1;
    localparam logic [1:0] OP_TICK     = 2'd2;
    localparam logic [1:0] OP_DISPATCH = 2'd3;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NOFLAGS = 2'd1;
    localparam logic [1:0] ST_BADTASK = 2'd2;
    localparam logic [1:0] ST_FULL    = 2'd3;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;       // capture the request and clear the walk results
        logic step;       // process the slot under the walk index
        logic finish;     // apply the request's final action and build the result
        logic out_take;   // result register has been taken downstream
    } efs_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic walk_last;  // walk index is on the last slot
        logic out_valid;  // result register holds a result
    } efs_stat_t;

endpackage

@@ sv/efs_ram.sv @@
// Generic RAM with one write port and one registered read port, used for per-slot payload.
// No dependencies.
module efs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write and one registered read a cycle.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ sv/efs_ctrl.sv @@
// Controller state machine of the event flag scheduler.
// Depends on efs_pkg for the command and status structs.
module efs_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic               out_stall,
    input  logic               walk_needed,
    output efs_pkg::efs_cmd_t  cmd,
    input  efs_pkg::efs_stat_t stat
);
    import efs_pkg::*;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_WALK  = 2'd2;
    localparam logic [1:0] S_DONE  = 2'd3;

    logic [1:0] state_reg, state_next;
    logic       accept;
    logic       room;

    // The result register frees up in the same cycle it is taken.
    assign room     = !stat.out_valid || !out_stall;
    assign in_stall = (state_reg != S_IDLE);
    assign accept   = in_valid && (state_reg == S_IDLE);

    always_comb
    begin
        state_next   = state_reg;
        cmd.load     = 1'b0;
        cmd.step     = 1'b0;
        cmd.finish   = 1'b0;
        cmd.out_take = stat.out_valid && !out_stall;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    // The load edge also reads slot 0, so the walk starts next cycle.
                    cmd.load   = 1'b1;
                    state_next = walk_needed ? S_WALK : S_DONE;
                end
            end
            S_WALK:
            begin
                cmd.step = 1'b1;
                if (stat.walk_last)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (room)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

@@ sv/efs_dp.sv @@
// Datapath of the event flag scheduler: pending flags, delay slot table,
// slot walk and result register. Depends on efs_pkg and efs_ram.
module efs_dp #(
    parameter int TASKS = 8,
    parameter int SLOTS = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [3:0]         cfg_data,
    input  logic [1:0]         opcode,
    input  logic [3:0]         task_id,
    input  logic [31:0]        event_flags,
    input  logic [31:0]        delay_ticks,
    input  logic               periodic,
    output logic               walk_needed,
    input  efs_pkg::efs_cmd_t  cmd,
    output efs_pkg::efs_stat_t stat,
    output logic [1:0]         status,
    output logic               task_found,
    output logic [2:0]         ready_task,
    output logic [31:0]        ready_flags,
    output logic               idle
);
    import efs_pkg::*;

    localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int TW = (TASKS > 1) ? $clog2(TASKS) : 1;
    // Slot payload word: task(4) | flags | countdown | reload.
    localparam int RW = 4 + 32 + 32 + 32;

    logic [3:0]        task_count_reg;
    logic [31:0]       pend_reg [TASKS];
    logic [SLOTS-1:0]  used_reg;

    logic [1:0]        op_reg;
    logic [3:0]        task_reg;
    logic [31:0]       flags_reg;
    logic [31:0]       delay_reg;
    logic              per_reg;
    logic [1:0]        chk_reg;

    logic [SW-1:0]     idx_reg;
    logic              match_hit_reg, free_hit_reg;
    logic [SW-1:0]     match_idx_reg, free_idx_reg;
    logic [31:0]       post_reg [TASKS];

    logic              ov_reg;
    logic [1:0]        st_reg;
    logic              found_reg;
    logic [2:0]        rtask_reg;
    logic [31:0]       rflags_reg;
    logic              idle_reg;

    logic              ram_we;
    logic [SW-1:0]     ram_waddr, ram_raddr;
    logic [RW-1:0]     ram_wdata, ram_rdata;

    logic [4:0]        live;
    logic [1:0]        chk;
    logic [3:0]        rd_task;
    logic [31:0]       rd_flags, rd_cnt, rd_rel, cnt_dec;
    logic              cur_used;
    logic              walk_clear;
    logic              fin_write;
    logic [SW-1:0]     fin_addr;
    logic [RW-1:0]     fin_data;
    logic              disp_hit;
    logic [TW-1:0]     disp_idx;

    // Argument check: zero flags first, then task range.
    assign live = ({1'b0, task_count_reg} < 5'(TASKS)) ? {1'b0, task_count_reg} : 5'(TASKS);
    always_comb
    begin
        if (event_flags == 32'd0)
            chk = ST_NOFLAGS;
        else if ({1'b0, task_id} >= live)
            chk = ST_BADTASK;
        else
            chk = ST_OK;
    end

    // Only tick, delayed send and clear walk the slot table.
    assign walk_needed = (opcode == OP_TICK) ||
                         ((opcode == OP_CLEAR) && (chk == ST_OK)) ||
                         ((opcode == OP_SEND) && (chk == ST_OK) && (delay_ticks != 32'd0));

    assign stat.walk_last = (idx_reg == SW'(SLOTS - 1));
    assign stat.out_valid = ov_reg;

    assign rd_task  = ram_rdata[RW-1 -: 4];
    assign rd_flags = ram_rdata[95:64];
    assign rd_cnt   = ram_rdata[63:32];
    assign rd_rel   = ram_rdata[31:0];
    assign cnt_dec  = rd_cnt - 32'd1;
    assign cur_used = used_reg[idx_reg];
    assign walk_clear = cmd.step && (op_reg == OP_TICK) && cur_used &&
                        (cnt_dec == 32'd0) && (rd_rel == 32'd0);

    // Lowest-numbered task with pending flags among the live tasks.
    always_comb
    begin
        disp_hit = 1'b0;
        disp_idx = '0;
        for (int t = TASKS - 1; t >= 0; t--)
        begin
            if ((pend_reg[t] != 32'd0) && (5'(t) < live))
            begin
                disp_hit = 1'b1;
                disp_idx = TW'(t);
            end
        end
    end

    // Final RAM write of a delayed send: refresh countdown or claim a slot.
    always_comb
    begin
        fin_write = 1'b0;
        fin_addr  = free_idx_reg;
        fin_data  = {task_reg, flags_reg, delay_reg, per_reg ? delay_reg : 32'd0};
        if (cmd.finish && (op_reg == OP_SEND) && (chk_reg == ST_OK) &&
            (delay_reg != 32'd0))
        begin
            if (match_hit_reg)
            begin
                // Refresh keeps task, flags and reload of the first send.
                fin_write = 1'b1;
                fin_addr  = match_idx_reg;
                fin_data  = {task_reg, flags_reg, delay_reg, ram_rdata[31:0]};
            end
            else if (free_hit_reg)
            begin
                fin_write = 1'b1;
            end
        end
    end

    // RAM port: walk reads ahead, tick writes back, send writes at finish.
    // Outside the walk the read port stays on the matched slot, so its reload
    // survives while the result waits for room.
    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = idx_reg;
        ram_wdata = {rd_task, rd_flags, cnt_dec, rd_rel};
        ram_raddr = cmd.load ? '0 : cmd.step ? SW'(idx_reg + SW'(1)) : match_idx_reg;
        if (cmd.step && (op_reg == OP_TICK) && cur_used)
        begin
            ram_we = 1'b1;
            if ((cnt_dec == 32'd0) && (rd_rel != 32'd0))
                ram_wdata = {rd_task, rd_flags, rd_rel, rd_rel};
        end
        if (cmd.step && stat.walk_last)
        begin
            // Hold the matched slot on the read port for a refresh.
            ram_raddr = match_idx_reg;
            if ((op_reg == OP_SEND) && !match_hit_reg && cur_used &&
                (rd_task == task_reg) && (rd_flags == flags_reg))
                ram_raddr = idx_reg;
        end
        if (fin_write)
        begin
            ram_we    = 1'b1;
            ram_waddr = fin_addr;
            ram_wdata = fin_data;
        end
    end

    efs_ram #(.WIDTH(RW), .DEPTH(SLOTS)) u_slot_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Request capture and slot walk bookkeeping.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg        <= opcode;
            task_reg      <= task_id;
            flags_reg     <= event_flags;
            delay_reg     <= delay_ticks;
            per_reg       <= periodic;
            chk_reg       <= chk;
            match_hit_reg <= 1'b0;
            free_hit_reg  <= 1'b0;
            match_idx_reg <= '0;
            free_idx_reg  <= '0;
            for (int t = 0; t < TASKS; t++)
                post_reg[t] <= 32'd0;
        end
        else if (cmd.step)
        begin
            if (cur_used && !match_hit_reg && (rd_task == task_reg) &&
                (rd_flags == flags_reg))
            begin
                match_hit_reg <= 1'b1;
                match_idx_reg <= idx_reg;
            end
            if (!cur_used && !free_hit_reg)
            begin
                free_hit_reg <= 1'b1;
                free_idx_reg <= idx_reg;
            end
            if ((op_reg == OP_TICK) && cur_used && (cnt_dec == 32'd0))
            begin
                for (int t = 0; t < TASKS; t++)
                    if (rd_task == 4'(t))
                        post_reg[t] <= post_reg[t] | rd_flags;
            end
        end
    end

    // Control state: register, pending flags, slot valid bits, walk index, result.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            task_count_reg <= 4'd0;
            used_reg       <= '0;
            idx_reg        <= '0;
            ov_reg         <= 1'b0;
            st_reg         <= ST_OK;
            found_reg      <= 1'b0;
            rtask_reg      <= 3'd0;
            rflags_reg     <= 32'd0;
            idle_reg       <= 1'b0;
            for (int t = 0; t < TASKS; t++)
                pend_reg[t] <= 32'd0;
        end
        else
        begin
            if (cfg_we)
                task_count_reg <= cfg_data;
            if (cmd.load)
                idx_reg <= '0;
            else if (cmd.step)
                idx_reg <= SW'(idx_reg + SW'(1));
            if (walk_clear)
                used_reg[idx_reg] <= 1'b0;
            if (cmd.out_take)
                ov_reg <= 1'b0;
            if (cmd.finish)
            begin
                ov_reg     <= 1'b1;
                st_reg     <= chk_reg;
                found_reg  <= 1'b0;
                rtask_reg  <= 3'd0;
                rflags_reg <= 32'd0;
                idle_reg   <= 1'b0;
                case (op_reg)
                    OP_SEND:
                    begin
                        if (chk_reg == ST_OK)
                        begin
                            if (delay_reg == 32'd0)
                            begin
                                for (int t = 0; t < TASKS; t++)
                                    if (task_reg == 4'(t))
                                        pend_reg[t] <= pend_reg[t] | flags_reg;
                            end
                            else if (!match_hit_reg && !free_hit_reg)
                                st_reg <= ST_FULL;
                            else if (!match_hit_reg)
                                used_reg[free_idx_reg] <= 1'b1;
                        end
                    end
                    OP_CLEAR:
                    begin
                        if (chk_reg == ST_OK)
                        begin
                            for (int t = 0; t < TASKS; t++)
                                if (task_reg == 4'(t))
                                    pend_reg[t] <= pend_reg[t] & ~flags_reg;
                            if (match_hit_reg)
                                used_reg[match_idx_reg] <= 1'b0;
                        end
                    end
                    OP_TICK:
                    begin
                        st_reg <= ST_OK;
                        for (int t = 0; t < TASKS; t++)
                            pend_reg[t] <= pend_reg[t] | post_reg[t];
                    end
                    default:
                    begin
                        st_reg <= ST_OK;
                        if (disp_hit)
                        begin
                            found_reg  <= 1'b1;
                            rtask_reg  <= 3'(disp_idx);
                            rflags_reg <= pend_reg[disp_idx];
                            pend_reg[disp_idx] <= 32'd0;
                        end
                        else
                        begin
                            idle_reg <= (used_reg == '0);
                        end
                    end
                endcase
            end
        end
    end

    assign status      = st_reg;
    assign task_found  = found_reg;
    assign ready_task  = rtask_reg;
    assign ready_flags = rflags_reg;
    assign idle        = idle_reg;

endmodule

@@ sv/event_flag_scheduler.sv @@
// Event flag scheduler top level: controller plus datapath.
// Dispatch, rejected and immediate requests go from the load straight to the done
// state; tick, delayed send and clear first walk the slot RAM one slot a cycle.
// One request at a time: the next request enters when the result is registered,
// and a stalled earlier result holds a request in the done state.
// Reset clears task_count, pending flags and slot valid bits.
module event_flag_scheduler #(
    parameter int TASKS = 8,
    parameter int SLOTS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [3:0]  cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  opcode,
    input  logic [3:0]  task_id,
    input  logic [31:0] event_flags,
    input  logic [31:0] delay_ticks,
    input  logic        periodic,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  status,
    output logic        task_found,
    output logic [2:0]  ready_task,
    output logic [31:0] ready_flags,
    output logic        idle
);
    import efs_pkg::*;

    efs_cmd_t  cmd;
    efs_stat_t stat;
    logic      walk_needed;

    efs_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .out_stall   (out_stall),
        .walk_needed (walk_needed),
        .cmd         (cmd),
        .stat        (stat)
    );

    efs_dp #(.TASKS(TASKS), .SLOTS(SLOTS)) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_data    (cfg_data),
        .opcode      (opcode),
        .task_id     (task_id),
        .event_flags (event_flags),
        .delay_ticks (delay_ticks),
        .periodic    (periodic),
        .walk_needed (walk_needed),
        .cmd         (cmd),
        .stat        (stat),
        .status      (status),
        .task_found  (task_found),
        .ready_task  (ready_task),
        .ready_flags (ready_flags),
        .idle        (idle)
    );

    assign out_valid = stat.out_valid;

endmodule

@@ bench/tb_event_flag_scheduler.sv @@
// Self-checking testbench for the event flag scheduler: a table of directed requests,
// then random requests, all checked against a scheduler predictor kept in this bench.
// Depends on efs_pkg and the event_flag_scheduler top level.
module tb_event_flag_scheduler;
    import efs_pkg::*;

    localparam int TASKS = 8;
    localparam int SLOTS = 16;

    typedef struct packed {
        logic [1:0]  status;
        logic        task_found;
        logic [2:0]  ready_task;
        logic [31:0] ready_flags;
        logic        idle;
    } sched_result_t;

    typedef struct {
        logic [1:0]  op;
        logic [3:0]  tid;
        logic [31:0] flags;
        logic [31:0] delay;
        logic        per;
        logic        has_known;
        sched_result_t known;
    } sched_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [3:0]  cfg_data = '0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [1:0]  opcode = '0;
    logic [3:0]  task_id = '0;
    logic [31:0] event_flags = '0;
    logic [31:0] delay_ticks = '0;
    logic        periodic = 1'b0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [1:0]  status;
    logic        task_found;
    logic [2:0]  ready_task;
    logic [31:0] ready_flags;
    logic        idle;

    event_flag_scheduler #(.TASKS(TASKS), .SLOTS(SLOTS)) u_dut (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_stall(in_stall), .opcode(opcode), .task_id(task_id),
        .event_flags(event_flags), .delay_ticks(delay_ticks), .periodic(periodic),
        .out_valid(out_valid), .out_stall(out_stall), .status(status),
        .task_found(task_found), .ready_task(ready_task), .ready_flags(ready_flags),
        .idle(idle)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Predictor state.
    logic [3:0]  m_task_count;
    logic [31:0] m_pending [TASKS];
    logic        m_used [SLOTS];
    logic [2:0]  m_task [SLOTS];
    logic [31:0] m_flags [SLOTS];
    logic [31:0] m_count [SLOTS];
    logic [31:0] m_reload [SLOTS];

    sched_result_t expected_results [$];
    int errors = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_cycles = 0;

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch: %s got %0h expected %0h", what, got, want);
        errors++;
    endtask

    function automatic int live_task_limit();
        return (m_task_count < TASKS) ? m_task_count : TASKS;
    endfunction

    function automatic int find_slot(input logic [3:0] tid, input logic [31:0] f);
        for (int i = 0; i < SLOTS; i++)
            if (m_used[i] && m_task[i] == tid && m_flags[i] == f)
                return i;
        return -1;
    endfunction

    // Compute the result of one request and update the predictor state.
    function automatic sched_result_t schedule_request(input logic [1:0] op,
            input logic [3:0] tid, input logic [31:0] f, input logic [31:0] d,
            input logic per);
        sched_result_t r;
        int s;
        r = '0;
        if (op == OP_SEND || op == OP_CLEAR)
        begin
            if (f == 0)
                r.status = ST_NOFLAGS;
            else if (tid >= live_task_limit())
                r.status = ST_BADTASK;
            else if (op == OP_CLEAR)
            begin
                m_pending[tid[2:0]] &= ~f;
                s = find_slot(tid, f);
                if (s >= 0)
                    m_used[s] = 1'b0;
            end
            else if (d == 0)
                m_pending[tid[2:0]] |= f;
            else
            begin
                s = find_slot(tid, f);
                if (s >= 0)
                    m_count[s] = d;
                else
                begin
                    for (int i = 0; i < SLOTS; i++)
                        if (!m_used[i] && s < 0)
                            s = i;
                    if (s < 0)
                        r.status = ST_FULL;
                    else
                    begin
                        m_used[s] = 1'b1;
                        m_task[s] = tid[2:0];
                        m_flags[s] = f;
                        m_count[s] = d;
                        m_reload[s] = per ? d : 32'd0;
                    end
                end
            end
        end
        else if (op == OP_TICK)
        begin
            for (int i = 0; i < SLOTS; i++)
            begin
                if (m_used[i])
                begin
                    m_count[i] = m_count[i] - 1;
                    if (m_count[i] == 0)
                    begin
                        m_pending[m_task[i]] |= m_flags[i];
                        if (m_reload[i] == 0)
                            m_used[i] = 1'b0;
                        else
                            m_count[i] = m_reload[i];
                    end
                end
            end
        end
        else
        begin
            for (int t = 0; t < live_task_limit(); t++)
            begin
                if (!r.task_found && m_pending[t] != 0)
                begin
                    r.task_found = 1'b1;
                    r.ready_task = t[2:0];
                    r.ready_flags = m_pending[t];
                    m_pending[t] = '0;
                end
            end
            if (!r.task_found)
            begin
                r.idle = 1'b1;
                for (int i = 0; i < SLOTS; i++)
                    if (m_used[i])
                        r.idle = 1'b0;
            end
        end
        return r;
    endfunction

    // Offer one request and wait for it to be accepted; valid drops only while idling.
    task automatic send_request(input sched_row_t row);
        sched_result_t r;
        while (send_idle_pct > 0 && $urandom_range(99, 0) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        opcode <= row.op;
        task_id <= row.tid;
        event_flags <= row.flags;
        delay_ticks <= row.delay;
        periodic <= row.per;
        in_valid <= 1'b1;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        r = schedule_request(row.op, row.tid, row.flags, row.delay, row.per);
        if (row.has_known && r != row.known)
            report_mismatch("directed table row", r[31:0], row.known[31:0]);
        expected_results.push_back(r);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (SLOTS + 8) @(posedge clk);
    endtask

    task automatic write_task_count(input logic [3:0] v);
        wait_drained();
        cfg_data <= v;
        cfg_we <= 1'b1;
        @(posedge clk);
        cfg_we <= 1'b0;
        m_task_count = v;
    endtask

    function automatic sched_row_t make_row(input logic [1:0] op, input logic [3:0] tid,
            input logic [31:0] f, input logic [31:0] d, input logic per);
        sched_row_t row;
        row.op = op;
        row.tid = tid;
        row.flags = f;
        row.delay = d;
        row.per = per;
        row.has_known = 1'b0;
        row.known = '0;
        return row;
    endfunction

    function automatic sched_row_t known_row(input sched_row_t row, input logic [1:0] st,
            input logic fnd, input logic [2:0] rt, input logic [31:0] rf, input logic idl);
        row.has_known = 1'b1;
        row.known = '{st, fnd, rt, rf, idl};
        return row;
    endfunction

    // Random request, mostly valid tasks and small delays so entries expire.
    function automatic sched_row_t random_row();
        logic [31:0] f;
        logic [31:0] d;
        int k;
        k = $urandom_range(9, 0);
        f = (k == 0) ? 32'd0 : (k < 4) ? $urandom() : (32'd1 << $urandom_range(31, 0));
        k = $urandom_range(9, 0);
        d = (k < 3) ? 32'd0 : (k < 9) ? $urandom_range(6, 1) : $urandom();
        return make_row(2'($urandom_range(3, 0)), (k == 5) ? 4'($urandom()) :
                        4'($urandom_range(7, 0)), f, d, 1'($urandom_range(1, 0)));
    endfunction

    // Result checking.
    always @(posedge clk)
    begin
        sched_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_results.size() == 0)
            begin
                report_mismatch("result with nothing expected", 32'd0, 32'd0);
            end
            else
            begin
                want = expected_results.pop_front();
                if (status != want.status)
                    report_mismatch("status", status, want.status);
                if (task_found != want.task_found)
                    report_mismatch("task_found", task_found, want.task_found);
                if (ready_task != want.ready_task)
                    report_mismatch("ready_task", ready_task, want.ready_task);
                if (ready_flags != want.ready_flags)
                    report_mismatch("ready_flags", ready_flags, want.ready_flags);
                if (idle != want.idle)
                    report_mismatch("idle", idle, want.idle);
            end
        end
    end

    // Receiver stall, with a long hold-off when one is requested.
    always @(posedge clk)
    begin
        if (hold_cycles > 0)
        begin
            out_stall <= 1'b1;
            hold_cycles <= hold_cycles - 1;
        end
        else
            out_stall <= (recv_stall_pct > 0) && ($urandom_range(99, 0) < recv_stall_pct);
    end

    initial
    begin
        #40000000;
        $display("status: fail");
        $finish;
    end

    initial
    begin
        sched_row_t dir_rows [$];
        m_task_count = '0;
        for (int t = 0; t < TASKS; t++)
            m_pending[t] = '0;
        for (int i = 0; i < SLOTS; i++)
        begin
            m_used[i] = 1'b0;
            m_task[i] = '0;
            m_flags[i] = '0;
            m_count[i] = '0;
            m_reload[i] = '0;
        end
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // After reset no task is registered.
        dir_rows.push_back(known_row(make_row(OP_DISPATCH, 4'd0, '0, '0, 1'b0),
                                     ST_OK, 1'b0, 3'd0, 32'd0, 1'b1));
        dir_rows.push_back(known_row(make_row(OP_SEND, 4'd0, 32'd1, '0, 1'b0),
                                     ST_BADTASK, 1'b0, 3'd0, 32'd0, 1'b0));
        dir_rows.push_back(known_row(make_row(OP_SEND, 4'd15, 32'd0, '0, 1'b0),
                                     ST_NOFLAGS, 1'b0, 3'd0, 32'd0, 1'b0));
        foreach (dir_rows[i])
            send_request(dir_rows[i]);
        dir_rows.delete();

        write_task_count(4'd15);
        // Immediate send at the extremes, then dispatch, a send to task 8 and a clear with no flags.
        dir_rows.push_back(make_row(OP_SEND, 4'd7, 32'hFFFF_FFFF, 32'd0, 1'b0));
        dir_rows.push_back(known_row(make_row(OP_DISPATCH, 4'd15, '1, '1, 1'b1),
                                     ST_OK, 1'b1, 3'd7, 32'hFFFF_FFFF, 1'b0));
        dir_rows.push_back(known_row(make_row(OP_SEND, 4'd8, 32'd1, '0, 1'b0),
                                     ST_BADTASK, 1'b0, 3'd0, 32'd0, 1'b0));
        dir_rows.push_back(known_row(make_row(OP_CLEAR, 4'd2, 32'd0, '0, 1'b0),
                                     ST_NOFLAGS, 1'b0, 3'd0, 32'd0, 1'b0));
        // Periodic entry, refresh keeps the reload, ticks and expiry.
        dir_rows.push_back(make_row(OP_SEND, 4'd0, 32'h8000_0001, 32'd2, 1'b1));
        dir_rows.push_back(make_row(OP_SEND, 4'd0, 32'h8000_0001, 32'd1, 1'b0));
        dir_rows.push_back(make_row(OP_TICK, 4'd9, '1, '1, 1'b1));
        dir_rows.push_back(make_row(OP_DISPATCH, 4'd0, '0, '0, 1'b0));
        dir_rows.push_back(make_row(OP_TICK, 4'd0, '0, '0, 1'b0));
        dir_rows.push_back(make_row(OP_TICK, 4'd0, '0, '0, 1'b0));
        dir_rows.push_back(make_row(OP_DISPATCH, 4'd0, '0, '0, 1'b0));
        // Clear with and without a matching entry.
        dir_rows.push_back(make_row(OP_CLEAR, 4'd0, 32'h8000_0001, '0, 1'b0));
        dir_rows.push_back(make_row(OP_CLEAR, 4'd3, 32'h0000_FFFF, '0, 1'b0));
        dir_rows.push_back(make_row(OP_SEND, 4'd1, 32'd4, 32'hFFFF_FFFF, 1'b1));
        dir_rows.push_back(make_row(OP_DISPATCH, 4'd0, '0, '0, 1'b0));
        foreach (dir_rows[i])
            send_request(dir_rows[i]);
        dir_rows.delete();

        // Fill the table, then one more delayed send reports full.
        for (int i = 0; i < SLOTS; i++)
            send_request(make_row(OP_SEND, 4'd2, 32'd1 << i, 32'd3, 1'b0));
        send_request(known_row(make_row(OP_SEND, 4'd2, 32'h0000_0003, 32'd3, 1'b0),
                               ST_FULL, 1'b0, 3'd0, 32'd0, 1'b0));
        for (int i = 0; i < 4; i++)
            send_request(make_row(OP_TICK, 4'd0, '0, '0, 1'b0));
        send_request(make_row(OP_CLEAR, 4'd1, 32'd4, '0, 1'b0));

        // Random phases over several task counts and idling patterns.
        for (int ph = 0; ph < 8; ph++)
        begin
            write_task_count((ph == 0) ? 4'd0 : (ph == 1) ? 4'd8 : (ph == 2) ? 4'd1 :
                             4'($urandom_range(15, 0)));
            send_idle_pct = (ph % 4 == 1 || ph % 4 == 3) ? 69 : 0;
            recv_stall_pct = (ph % 4 == 2) ? 69 : (ph % 4 == 3) ? 14 : 0;
            if (ph % 4 == 3)
                send_idle_pct = 14;
            if (ph == 4)
                hold_cycles = 400;
            for (int n = 0; n < 200; n++)
            begin
                if (ph == 5 && n == 100)
                    wait_drained();
                send_request(random_row());
            end
        end
        send_idle_pct = 0;
        recv_stall_pct = 0;
        wait_drained();
        if (errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end
endmodule
